// ===== src/spq_pkg.sv =====
// Package with the shared constants, types and codes of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    // Queue geometry and field widths.
    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    // Operation codes carried in the cmd field.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef logic [PRIO_WIDTH-1:0] prio_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // Controller states.
    typedef enum logic
    {
        ST_NO_RESULT,
        ST_RESULT
    } spq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
    } spq_cmd_t;

endpackage
`default_nettype wire

// ===== src/spq_if.sv =====
// Interfaces for the request and response channels of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if;
    import spq_pkg::*;

    logic  valid;
    logic  ready;
    logic  cmd;
    elem_t elem;
    prio_t priority_req;

    modport source (output valid, output cmd, output elem, output priority_req, input ready);
    modport sink   (input valid, input cmd, input elem, input priority_req, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic   valid;
    logic   ready;
    elem_t  top_elem;
    prio_t  top_priority;
    count_t count;
    logic   is_empty;
    logic   error;

    modport source (output valid, output top_elem, output top_priority, output count,
                    output is_empty, output error, input ready);
    modport sink   (input valid, input top_elem, input top_priority, input count,
                    input is_empty, input error, output ready);
endinterface
`default_nettype wire

// ===== src/spq_ctrl.sv =====
// Controller: handshake state machine that tracks the pending response.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spq_pkg::spq_cmd_t      cmd
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NO_RESULT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a new transaction always leaves a result in the output register.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_NO_RESULT:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_ready && !in_valid)
                begin
                    state_next = ST_NO_RESULT;
                end
            end
            default:
            begin
                state_next = ST_NO_RESULT;
            end
        endcase
    end

    // Outputs: accept when the output register is empty or is being drained.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_NO_RESULT:
            begin
                in_ready = 1'b1;
            end
            ST_RESULT:
            begin
                in_ready  = out_ready;
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = in_valid && in_ready;
    end

endmodule
`default_nettype wire

// ===== src/spq_dpath.sv =====
// Datapath: shift-register cells kept sorted by priority, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module spq_dpath
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spq_pkg::spq_cmd_t    cmd,
    input  wire logic                 op,
    input  wire spq_pkg::elem_t       elem,
    input  wire spq_pkg::prio_t       priority_req,
    output spq_pkg::elem_t            top_elem,
    output spq_pkg::prio_t            top_priority,
    output spq_pkg::count_t           count,
    output logic                      is_empty,
    output logic                      error
);
    import spq_pkg::*;

    // Cell contents have no reset; only slots below the count are ever read.
    elem_t  elem_cell_reg [CAPACITY];
    prio_t  prio_cell_reg [CAPACITY];
    elem_t  elem_cell_next [CAPACITY];
    prio_t  prio_cell_next [CAPACITY];
    logic   [CAPACITY-1:0] keep;
    count_t count_reg;
    count_t count_next;
    logic   full;
    logic   empty;
    logic   do_push;
    logic   do_pop;

    elem_t  top_elem_reg;
    prio_t  top_prio_reg;
    count_t out_count_reg;
    logic   empty_reg;
    logic   error_reg;

    assign full    = (count_reg == count_t'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign do_push = (op == CMD_PUSH) && !full;
    assign do_pop  = (op == CMD_POP) && !empty;

    // Each cell keeps its entry when it is valid and not above the new priority.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (count_t'(i) < count_reg) && (prio_cell_reg[i] <= priority_req);
        end
    end

    // Per-cell next value: insert at the first cell that does not keep, or shift down.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            elem_cell_next[i] = elem_cell_reg[i];
            prio_cell_next[i] = prio_cell_reg[i];
            if (do_push && !keep[i])
            begin
                if (i == 0)
                begin
                    elem_cell_next[i] = elem;
                    prio_cell_next[i] = priority_req;
                end
                else if (keep[i-1])
                begin
                    elem_cell_next[i] = elem;
                    prio_cell_next[i] = priority_req;
                end
                else
                begin
                    elem_cell_next[i] = elem_cell_reg[i-1];
                    prio_cell_next[i] = prio_cell_reg[i-1];
                end
            end
            else if (do_pop && (i < CAPACITY - 1))
            begin
                elem_cell_next[i] = elem_cell_reg[i+1];
                prio_cell_next[i] = prio_cell_reg[i+1];
            end
        end
    end

    // Entry count after the transaction.
    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    // Count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= count_next;
        end
    end

    // Cell registers and the result register, loaded on each transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                elem_cell_reg[i] <= elem_cell_next[i];
                prio_cell_reg[i] <= prio_cell_next[i];
            end
            top_elem_reg  <= (count_next == '0) ? '0 : elem_cell_next[0];
            top_prio_reg  <= (count_next == '0) ? '0 : prio_cell_next[0];
            out_count_reg <= count_next;
            empty_reg     <= (count_next == '0);
            error_reg     <= !(do_push || do_pop);
        end
    end

    assign top_elem     = top_elem_reg;
    assign top_priority = top_prio_reg;
    assign count        = out_count_reg;
    assign is_empty     = empty_reg;
    assign error        = error_reg;

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and datapath.
//
// Usage: the request channel carries one transaction per operation: cmd selects
// a push of elem with priority_req or a pop of the front entry. Entries are
// kept sorted by ascending priority; equal priorities leave in arrival order.
// Every request yields exactly one response transaction with the front entry,
// the entry count, an empty flag and an error flag. A push on a full queue or
// a pop on an empty queue leaves the queue unchanged and sets error.
// Response: valid in the cycle after the request is accepted.
// Throughput: one request per cycle while ready is high; all cells compare
// against the new priority in parallel and shift in the same cycle as the request.
// Stalls: the response waits in an output register; while the receiver holds
// ready low, a new request is accepted only in the cycle the response leaves.
// Reset: rst_n clears the entry count and the pending response; the queue
// starts empty and is ready at once.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue
(
    input wire logic  clk,
    input wire logic  rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    // Handshake control.
    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Sorted cells and result register.
    spq_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (req.cmd),
        .elem         (req.elem),
        .priority_req (req.priority_req),
        .top_elem     (rsp.top_elem),
        .top_priority (rsp.top_priority),
        .count        (rsp.count),
        .is_empty     (rsp.is_empty),
        .error        (rsp.error)
    );

endmodule
`default_nettype wire
